/* design/rau_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_DONE
	} state_t;
endpackage

/* design/rau_divider.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle; remainder also given.
// Depends on nothing.
module rau_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;
endmodule

/* design/rational_arith_unit_core.sv */
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit.
// Depends on rau_pkg and rau_divider.
//
// Usage: drive opcode and the four operands with start high while busy is
// low; that edge takes the beat. busy stays high while the item is worked.
// The result (result_num, result_den, status) is shown for exactly one cycle
// with done high and cannot be held off by the receiver.
// Two cross products (three for add and subtract) go through one multiplier,
// one per cycle. The gcd is a Euclid loop on the shared 2*VALUE_WIDTH-bit
// divider; two more divisions reduce the
// numerator and denominator. Zero denominators and divide by zero go straight
// to the done state; a zero numerator still runs the two reducing divisions.
// One item is worked at a time.
// Reset returns the sequencer to idle with no result pending.
module rational_arith_unit_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	input  logic [1:0]             opcode,
	input  logic signed [31:0]     a_num,
	input  logic signed [31:0]     a_den,
	input  logic signed [31:0]     b_num,
	input  logic signed [31:0]     b_den,
	output logic signed [31:0]     result_num,
	output logic [30:0]            result_den,
	output logic [1:0]             status
);
	localparam int VW = VALUE_WIDTH;
	localparam int DW = 2 * VALUE_WIDTH;

	rau_pkg::state_t state_q, state_d;

	logic [VW-1:0] am_q, adm_q, bm_q, bdm_q;
	logic          an_q, ad_q, bn_q, bd_q;
	logic [1:0]    op_q;
	logic [DW-1:0] m1_q, m2_q, dm_q, nm_q, x_q, y_q, g_q;
	logic          nneg_q;
	logic [1:0]    mcnt_q;

	logic [VW-1:0] mul_a, mul_b;
	logic [DW-1:0] mul_p;
	logic          div_go, div_done;
	logic [DW-1:0] div_n, div_d, div_quo, div_rem;
	logic          div_wait_q;

	function automatic logic [VW-1:0] mag(input logic [31:0] raw);
		logic [VW-1:0] v;
		v = raw[VW-1:0];
		return v[VW-1] ? (~v + 1'b1) : v;
	endfunction

	// magnitude of the most negative value wraps to itself, which is correct
	assign mul_p = DW'(mul_a) * DW'(mul_b);

	always_comb begin
		mul_a = am_q;
		mul_b = bdm_q;
		case (mcnt_q)
			2'd0: begin
				mul_a = am_q;
				mul_b = (op_q == rau_pkg::OP_MUL) ? bm_q : bdm_q;
			end
			2'd1: begin
				mul_a = adm_q;
				mul_b = (op_q == rau_pkg::OP_DIV) ? bm_q : bdm_q;
			end
			2'd2: begin
				mul_a = bm_q;
				mul_b = adm_q;
			end
			default: begin
				mul_a = am_q;
				mul_b = bdm_q;
			end
		endcase
	end

	rau_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(div_n), .divisor(div_d),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	logic          s1, s2;
	logic [DW-1:0] limit;
	logic          zero_in;
	logic [DW-1:0] nm_red, dm_red;
	logic [DW-1:0] nm_c;
	logic          nneg_c;

	assign limit = DW'(1) << (VW - 1);
	assign zero_in = (mag(a_den) == '0) || (mag(b_den) == '0)
		|| ((opcode == rau_pkg::OP_DIV) && (mag(b_num) == '0));

	always_comb begin
		s1 = an_q ^ bd_q;
		s2 = bn_q ^ ad_q ^ (op_q == rau_pkg::OP_SUB);
	end

	always_comb begin
		nm_c   = m1_q;
		nneg_c = an_q ^ bd_q;
		case (op_q)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				if (s1 == s2) begin
					nm_c   = m1_q + m2_q;
					nneg_c = s1;
				end else if (m1_q >= m2_q) begin
					nm_c   = m1_q - m2_q;
					nneg_c = s1;
				end else begin
					nm_c   = m2_q - m1_q;
					nneg_c = s2;
				end
			end
			rau_pkg::OP_MUL: begin
				nm_c   = m1_q;
				nneg_c = an_q ^ bn_q;
			end
			default: begin
				nm_c   = m1_q;
				nneg_c = an_q ^ bd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::S_IDLE: if (start) state_d = zero_in ? rau_pkg::S_DONE : rau_pkg::S_MUL1;
			rau_pkg::S_MUL1: state_d = rau_pkg::S_MUL2;
			rau_pkg::S_MUL2: state_d = (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB)
				? rau_pkg::S_MUL3 : rau_pkg::S_COMB;
			rau_pkg::S_MUL3: state_d = rau_pkg::S_COMB;
			rau_pkg::S_COMB: state_d = rau_pkg::S_GCD;
			rau_pkg::S_GCD: if (!div_wait_q && y_q == '0) state_d = rau_pkg::S_DIVN;
			rau_pkg::S_DIVN: if (div_done) state_d = rau_pkg::S_DIVD;
			rau_pkg::S_DIVD: if (div_done) state_d = rau_pkg::S_DONE;
			rau_pkg::S_DONE: state_d = rau_pkg::S_IDLE;
			default: state_d = rau_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		div_go = 1'b0;
		div_n  = x_q;
		div_d  = y_q;
		case (state_q)
			rau_pkg::S_GCD: begin
				div_go = !div_wait_q && (y_q != '0);
			end
			rau_pkg::S_DIVN: begin
				div_n = nm_q;
				div_d = g_q;
				div_go = !div_wait_q;
			end
			rau_pkg::S_DIVD: begin
				div_n = dm_q;
				div_d = g_q;
				div_go = !div_wait_q;
			end
			default: div_go = 1'b0;
		endcase
	end

	assign nm_red = m1_q;
	assign dm_red = div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_wait_q <= 1'b0;
			done       <= 1'b0;
			mcnt_q     <= '0;
		end else begin
			done <= (state_q == rau_pkg::S_DONE);
			if (div_go) div_wait_q <= 1'b1;
			else if (div_done) div_wait_q <= 1'b0;
			case (state_q)
				rau_pkg::S_IDLE: mcnt_q <= '0;
				rau_pkg::S_MUL1, rau_pkg::S_MUL2: mcnt_q <= mcnt_q + 1'b1;
				default: mcnt_q <= mcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::S_IDLE: begin
				op_q  <= opcode;
				am_q  <= mag(a_num);
				adm_q <= mag(a_den);
				bm_q  <= mag(b_num);
				bdm_q <= mag(b_den);
				an_q  <= a_num[VW-1];
				ad_q  <= a_den[VW-1];
				bn_q  <= b_num[VW-1];
				bd_q  <= b_den[VW-1];
				result_num <= '0;
				result_den <= 31'd1;
				status <= zero_in ? rau_pkg::ST_ZDEN : rau_pkg::ST_OK;
			end
			rau_pkg::S_MUL1: m1_q <= mul_p;
			rau_pkg::S_MUL2: dm_q <= mul_p;
			rau_pkg::S_MUL3: m2_q <= mul_p;
			rau_pkg::S_COMB: begin
				nm_q   <= nm_c;
				nneg_q <= nneg_c;
				// Euclid runs on (den, num); a zero numerator ends it at once
				x_q <= dm_q;
				y_q <= nm_c;
			end
			rau_pkg::S_GCD: begin
				if (div_done) begin
					x_q <= y_q;
					y_q <= div_rem;
				end
				g_q <= x_q;
			end
			rau_pkg::S_DIVN: if (div_done) m1_q <= div_quo;
			rau_pkg::S_DIVD: begin
				if (div_done) begin
					if (nm_q == '0) begin
						result_num <= '0;
						result_den <= 31'd1;
						status <= rau_pkg::ST_OK;
					end else if (dm_red > limit - 1'b1
						|| nm_red > ((nneg_q ^ ad_q ^ ((op_q == rau_pkg::OP_DIV) ? bn_q : bd_q))
						? limit : limit - 1'b1)) begin
						result_num <= '0;
						result_den <= 31'd1;
						status <= rau_pkg::ST_OVF;
					end else begin
						result_num <= (nneg_q ^ ad_q ^ ((op_q == rau_pkg::OP_DIV) ? bn_q : bd_q))
							? 32'(-64'(nm_red)) : 32'(nm_red);
						result_den <= 31'(dm_red);
						status <= rau_pkg::ST_OK;
					end
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != rau_pkg::S_IDLE);

	a_done_after_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rau_pkg::S_DONE) |=> done)
		else $error("done missing after final state");
	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without work");
	a_div_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_wait_q)
		else $error("divider restarted while running");
	a_status_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_den != '0))
		else $error("zero denominator out");
endmodule
